// ===== rtl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants of the domino packing profile engine.
// ----------------------------------------------------------------------------
package dpp_pkg;

    localparam int CELL_BITS = 16;
    localparam int NUM_CELLS = 8;
    localparam int ROWS_BITS = 4;
    localparam logic [ROWS_BITS-1:0] ROWS_RESET = 4'd8;

    typedef struct packed {
        logic capture;
        logic hold_in;
        logic hold_cur;
        logic go;
        logic horiz;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic pass_done;
    } stat_t;

endpackage

// ===== rtl/dpp_ifs.sv =====
// ----------------------------------------------------------------------------
// dpp_ifs
// Column, result and configuration channels of the domino packing engine.
// ----------------------------------------------------------------------------
interface dpp_col_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cell_0;
    logic signed [15:0] cell_1;
    logic signed [15:0] cell_2;
    logic signed [15:0] cell_3;
    logic signed [15:0] cell_4;
    logic signed [15:0] cell_5;
    logic signed [15:0] cell_6;
    logic signed [15:0] cell_7;
    logic               last_column;

    modport source (output valid, cell_0, cell_1, cell_2, cell_3, cell_4, cell_5,
                    cell_6, cell_7, last_column, input ready);
    modport sink (input valid, cell_0, cell_1, cell_2, cell_3, cell_4, cell_5,
                  cell_6, cell_7, last_column, output ready);
endinterface

interface dpp_res_if #(parameter int SCORE_BITS = 47);
    logic                  valid;
    logic                  ready;
    logic [SCORE_BITS-1:0] best_total;
    logic                  saturated;

    modport source (output valid, best_total, saturated, input ready);
    modport sink (input valid, best_total, saturated, output ready);
endinterface

interface dpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] rows_in_use;

    modport source (output valid, rows_in_use, input ready);
    modport sink (input valid, rows_in_use, output ready);
endinterface

// ===== rtl/domino_packing_profile_dp.sv =====
// ----------------------------------------------------------------------------
// domino_packing_profile_dp
// Maximum-weight domino packing over a grid streamed one column at a time.
//
// The col channel carries one grid column per transfer: eight signed cells
// and a last-column mark. A column is processed when the next one arrives,
// so a column transfer that is not the last only stores the column, or runs
// one profile pass over the stored one. The last column runs up to two
// passes and then places one result on the res channel.
// A pass sweeps every row once; each row visits all 2**MAX_ROWS profiles
// with three score-memory reads per profile and then drains; the score
// memory has a single read port.
// The cfg channel writes rows_in_use and is always ready; write it only
// while no column is in flight. After reset rows_in_use is 8 and the grid
// is empty. A result that the receiver has not taken stays in the output
// register; further columns are still taken, and only the next result
// waits for it. After each result the grid state returns to empty.
// ----------------------------------------------------------------------------
module domino_packing_profile_dp #(
    parameter int MAX_ROWS   = 8,
    parameter int SCORE_BITS = 47
) (
    input  logic      clk,
    input  logic      rst_n,
    dpp_col_if.sink   col,
    dpp_res_if.source res,
    dpp_cfg_if.sink   cfg
);

    dpp_pkg::cmd_t                 cmd;
    dpp_pkg::stat_t                stat;
    logic [dpp_pkg::CELL_BITS-1:0] cells [dpp_pkg::NUM_CELLS];
    logic [SCORE_BITS-1:0]         best_total;
    logic                          saturated;

    assign cells[0] = col.cell_0;
    assign cells[1] = col.cell_1;
    assign cells[2] = col.cell_2;
    assign cells[3] = col.cell_3;
    assign cells[4] = col.cell_4;
    assign cells[5] = col.cell_5;
    assign cells[6] = col.cell_6;
    assign cells[7] = col.cell_7;

    assign cfg.ready = 1'b1;

    dpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (col.valid),
        .in_last   (col.last_column),
        .in_ready  (col.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dpp_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cells   (cells),
        .cfg_we     (cfg.valid),
        .cfg_rows   (cfg.rows_in_use),
        .best_total (best_total),
        .saturated  (saturated)
    );

    assign res.best_total = best_total;
    assign res.saturated  = saturated;

endmodule

// ===== rtl/dpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpp_ctrl
// Controller: accepts columns, starts profile passes and hands out results.
// ----------------------------------------------------------------------------
module dpp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  dpp_pkg::stat_t stat,
    output dpp_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PASS_A = 4'b0010,
        S_PASS_B = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   held_reg, held_next;
    logic   last_reg, last_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    if (held_reg)
                    begin
                        cmd.go     = 1'b1;
                        cmd.horiz  = 1'b1;
                        state_next = S_PASS_A;
                    end
                    else if (!in_last)
                    begin
                        cmd.hold_in = 1'b1;
                        held_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.go     = 1'b1;
                        state_next = S_PASS_B;
                    end
                end
            end
            S_PASS_A:
            begin
                if (stat.pass_done)
                begin
                    if (last_reg)
                    begin
                        cmd.go     = 1'b1;
                        state_next = S_PASS_B;
                    end
                    else
                    begin
                        cmd.hold_cur = 1'b1;
                        held_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_PASS_B:
            begin
                if (stat.pass_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.clear      = 1'b1;
                    held_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dpp_datapath.sv =====
// ----------------------------------------------------------------------------
// dpp_datapath
// Datapath: column registers, profile score memory and the row sweep that
// moves every profile through one row per sweep.
// ----------------------------------------------------------------------------
module dpp_datapath #(
    parameter int MAX_ROWS   = 8,
    parameter int SCORE_BITS = 47
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dpp_pkg::cmd_t                    cmd,
    output dpp_pkg::stat_t                   stat,
    input  logic [dpp_pkg::CELL_BITS-1:0]    in_cells [dpp_pkg::NUM_CELLS],
    input  logic                             cfg_we,
    input  logic [dpp_pkg::ROWS_BITS-1:0]    cfg_rows,
    output logic [SCORE_BITS-1:0]            best_total,
    output logic                             saturated
);

    localparam int NPROF  = 2 ** MAX_ROWS;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = MAX_ROWS + 1;
    localparam int CB     = dpp_pkg::CELL_BITS;
    localparam int RB     = dpp_pkg::ROWS_BITS;
    localparam logic [ROW_W-1:0]      LAST_ROW  = ROW_W'(MAX_ROWS - 1);
    localparam logic [MAX_ROWS-1:0]   LAST_PROF = '1;
    localparam logic [SCORE_BITS-1:0] TOP       = '1;
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_COVER = 2'd1;
    localparam logic [1:0] SLOT_VERT  = 2'd2;

    logic [RB-1:0]         rows_reg;
    logic [CB-1:0]         cur_reg  [MAX_ROWS];
    logic [CB-1:0]         held_reg [MAX_ROWS];
    logic                  horiz_reg;
    logic                  fresh_reg;
    logic                  bank_reg;
    logic                  sat_reg;
    logic                  running_reg;
    logic                  drain_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [MAX_ROWS-1:0]   prof_reg;
    logic [1:0]            slot_reg;

    logic [SCORE_BITS-1:0] score_mem [2*NPROF];
    logic [NPROF-1:0]      valid_reg [2];

    logic [SCORE_BITS-1:0] rd_score_reg;
    logic                  rd_v_reg;
    logic                  rd_en_reg;
    logic                  rd_srcv_reg;
    logic                  rd_zero_reg;
    logic [1:0]            rd_slot_reg;
    logic [MAX_ROWS-1:0]   rd_dest_reg;
    logic [CB-1:0]         rd_gain_reg;

    logic                  acc_v_reg, acc_v_next;
    logic [SCORE_BITS-1:0] acc_s_reg, acc_s_next;
    logic                  best0_v_reg;
    logic [SCORE_BITS-1:0] best0_reg;
    logic [SCORE_BITS-1:0] best_total_reg;
    logic                  saturated_reg;

    logic [RB-1:0]         k;
    logic [RB-1:0]         row_ext;
    logic                  normal;
    logic                  vert_ok;
    logic [ROW_W-1:0]      r1;
    logic [CB-1:0]         a_r, a_r1, b_r;
    logic signed [CB:0]    h_sum, v_sum;
    logic                  h_pos, v_pos;
    logic                  dbit, dbit1;
    logic [MAX_ROWS-1:0]   bitr, bitr1;
    logic                  issue;
    logic                  en;
    logic [MAX_ROWS-1:0]   src;
    logic [CB-1:0]         gain;

    logic [SCORE_BITS-1:0] src_score;
    logic [SCORE_BITS:0]   sum;
    logic                  hit_top;
    logic [SCORE_BITS-1:0] cand;
    logic                  use_src;
    logic                  base_v;
    logic                  take;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;

    // Row decode and pair sums for the current sweep position.
    always_comb
    begin
        k       = (rows_reg > RB'(MAX_ROWS)) ? RB'(MAX_ROWS) : rows_reg;
        row_ext = RB'(row_reg);
        normal  = row_ext < k;
        vert_ok = (row_ext + RB'(1)) < k;
        r1      = (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
        a_r     = horiz_reg ? held_reg[row_reg] : cur_reg[row_reg];
        a_r1    = horiz_reg ? held_reg[r1] : cur_reg[r1];
        b_r     = cur_reg[row_reg];
        h_sum   = $signed({a_r[CB-1], a_r}) + $signed({b_r[CB-1], b_r});
        v_sum   = $signed({a_r[CB-1], a_r}) + $signed({a_r1[CB-1], a_r1});
        h_pos   = !h_sum[CB] && (h_sum != '0);
        v_pos   = !v_sum[CB] && (v_sum != '0);
        dbit    = prof_reg[row_reg];
        dbit1   = prof_reg[r1];
        bitr    = MAX_ROWS'(1) << row_reg;
        bitr1   = MAX_ROWS'(1) << r1;
        issue   = running_reg && !drain_reg;
    end

    // Source profile and gain of each of the three candidate moves.
    always_comb
    begin
        en   = 1'b0;
        src  = prof_reg;
        gain = '0;
        unique case (slot_reg)
            SLOT_EMPTY:
            begin
                if (!dbit)
                begin
                    en = 1'b1;
                end
                else if (normal)
                begin
                    en   = horiz_reg && h_pos;
                    src  = prof_reg & ~bitr;
                    gain = h_sum[CB-1:0];
                end
            end
            SLOT_COVER:
            begin
                en  = !dbit;
                src = prof_reg | bitr;
            end
            SLOT_VERT:
            begin
                en   = normal && !dbit && vert_ok && dbit1 && v_pos;
                src  = prof_reg & ~bitr1;
                gain = v_sum[CB-1:0];
            end
            default:
            begin
                en = 1'b0;
            end
        endcase
    end

    // Candidate evaluation and running maximum for one destination profile.
    always_comb
    begin
        src_score  = rd_zero_reg ? '0 : rd_score_reg;
        sum        = {1'b0, src_score} + (SCORE_BITS + 1)'(rd_gain_reg);
        hit_top    = (rd_gain_reg != '0) && (sum >= {1'b0, TOP});
        cand       = hit_top ? TOP : sum[SCORE_BITS-1:0];
        use_src    = rd_v_reg && rd_en_reg && rd_srcv_reg;
        base_v     = (rd_slot_reg == SLOT_EMPTY) ? 1'b0 : acc_v_reg;
        take       = use_src && (!base_v || (cand > acc_s_reg));
        acc_v_next = acc_v_reg;
        acc_s_next = acc_s_reg;
        if (rd_v_reg)
        begin
            acc_v_next = take || base_v;
            acc_s_next = take ? cand : acc_s_reg;
        end
        wr_en   = rd_v_reg && (rd_slot_reg == SLOT_VERT);
        wr_addr = {~bank_reg, rd_dest_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            score_mem[wr_addr] <= acc_s_next;
        end
        rd_score_reg <= score_mem[{bank_reg, src}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                cur_reg[i] <= in_cells[i];
            end
        end
        if (cmd.hold_in)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                held_reg[i] <= in_cells[i];
            end
        end
        else if (cmd.hold_cur)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                held_reg[i] <= cur_reg[i];
            end
        end
        if (cmd.out_load)
        begin
            best_total_reg <= best0_v_reg ? best0_reg : '0;
            saturated_reg  <= sat_reg;
        end
        if (wr_en && (rd_dest_reg == '0))
        begin
            best0_reg <= acc_s_next;
        end
        acc_s_reg    <= acc_s_next;
        rd_gain_reg  <= gain;
        rd_dest_reg  <= prof_reg;
        rd_slot_reg  <= slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= dpp_pkg::ROWS_RESET;
            horiz_reg   <= 1'b0;
            fresh_reg   <= 1'b1;
            bank_reg    <= 1'b0;
            sat_reg     <= 1'b0;
            running_reg <= 1'b0;
            drain_reg   <= 1'b0;
            row_reg     <= '0;
            prof_reg    <= '0;
            slot_reg    <= SLOT_EMPTY;
            valid_reg   <= '{default: '0};
            rd_v_reg    <= 1'b0;
            rd_en_reg   <= 1'b0;
            rd_srcv_reg <= 1'b0;
            rd_zero_reg <= 1'b0;
            acc_v_reg   <= 1'b0;
            best0_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rows_reg <= cfg_rows;
            end
            rd_v_reg    <= issue;
            rd_en_reg   <= en;
            rd_srcv_reg <= fresh_reg ? (src == '0) : valid_reg[bank_reg][src];
            rd_zero_reg <= fresh_reg;
            acc_v_reg   <= acc_v_next;
            if (wr_en)
            begin
                valid_reg[~bank_reg][rd_dest_reg] <= acc_v_next;
                if (rd_dest_reg == '0)
                begin
                    best0_v_reg <= acc_v_next;
                end
            end
            if (cmd.clear)
            begin
                sat_reg <= 1'b0;
            end
            else if (use_src && hit_top)
            begin
                sat_reg <= 1'b1;
            end
            if (cmd.go)
            begin
                // A pass that starts on the final drain of the previous one
                // still has to swap to the bank that the last row wrote.
                bank_reg    <= bank_reg ^ running_reg;
                running_reg <= 1'b1;
                drain_reg   <= 1'b0;
                row_reg     <= '0;
                prof_reg    <= '0;
                slot_reg    <= SLOT_EMPTY;
                horiz_reg   <= cmd.horiz;
            end
            else if (issue)
            begin
                if (slot_reg == SLOT_VERT)
                begin
                    slot_reg <= SLOT_EMPTY;
                    prof_reg <= prof_reg + MAX_ROWS'(1);
                    if (prof_reg == LAST_PROF)
                    begin
                        drain_reg <= 1'b1;
                    end
                end
                else
                begin
                    slot_reg <= slot_reg + 2'd1;
                end
            end
            else if (running_reg)
            begin
                drain_reg <= 1'b0;
                bank_reg  <= ~bank_reg;
                fresh_reg <= 1'b0;
                row_reg   <= (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
                if (row_reg == LAST_ROW)
                begin
                    running_reg <= 1'b0;
                end
            end
            if (cmd.clear)
            begin
                fresh_reg <= 1'b1;
            end
        end
    end

    assign stat.pass_done = running_reg && drain_reg && (row_reg == LAST_ROW);
    assign best_total     = best_total_reg;
    assign saturated      = saturated_reg;

endmodule
